### hdl/ahbd_pkg.sv
// Shared types, constants and control bundles for the allpass halfband decimator.
// No dependencies; the controller, datapath and top level import this package.
`default_nettype none

package ahbd_pkg;

  // Width of the branch state, with 20 fraction bits.
  localparam int SW = 24;
  // Fraction bits of the allpass coefficients.
  localparam int FRAC = 15;

  typedef logic signed [SW-1:0]  state_t;
  typedef logic signed [SW+2:0]  wide_t;
  typedef logic signed [SW:0]    mop_t;
  typedef logic signed [16:0]    coef_t;
  typedef logic signed [SW+17:0] prod_t;

  // Allpass section coefficients, Q15.
  localparam coef_t K_EVEN0 = 17'sd2616;
  localparam coef_t K_EVEN1 = 17'sd17864;
  localparam coef_t K_ODD0  = 17'sd9300;
  localparam coef_t K_ODD1  = 17'sd27336;

  // Divide by 5 through a reciprocal: floor(b * 52429 / 2^18) is exact for b below 2^16.
  localparam coef_t RECIP5      = 17'sd52429;
  localparam int    RECIP_SHIFT = 18;
  // Quotient magnitude above 8191 saturates, so larger inputs are clamped here.
  localparam logic [15:0] B_LIMIT = 16'd40960;
  localparam logic [13:0] OUT_MAX = 14'h1FFF;

  // Multiplier operand selects.
  localparam logic [1:0] MSEL_SEC0 = 2'd0;
  localparam logic [1:0] MSEL_SEC1 = 2'd1;
  localparam logic [1:0] MSEL_OUT  = 2'd2;

  localparam wide_t WMAX = (wide_t'(1) <<< (SW - 1)) - wide_t'(1);
  localparam wide_t WMIN = -(wide_t'(1) <<< (SW - 1));

  typedef struct packed {
    logic       load_x;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       upd_mid;
    logic       upd_out;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic phase;
    logic out_busy;
  } status_t;

  // Clamp a widened value to the signed state range.
  function automatic state_t sat_state(input wide_t v);
    state_t r;
    if (v > WMAX) begin
      r = state_t'(WMAX);
    end else if (v < WMIN) begin
      r = state_t'(WMIN);
    end else begin
      r = state_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/allpass_halfband_decimator.sv
// Top level of the 2:1 polyphase allpass halfband decimator.
// Depends on ahbd_pkg, ahbd_ctrl and ahbd_datapath.
//
// Takes one 16-bit sample per input beat and returns one 14-bit sample for every
// second input (the even-phase ones). One multiplier is shared by both allpass
// sections and the output scaling, so a sample is worked on serially: an
// odd-phase input keeps the input side stalled through both allpass sections,
// an even-phase input also through the output scaling. A result sits in an
// output register, so the next input is taken while it waits; a new result
// waits only if the previous one has not yet been taken.
`default_nettype none

module allpass_halfband_decimator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               audio_valid,
  output logic                    audio_stall,
  input  wire logic signed [15:0] audio_sample,
  output logic                    decimated_valid,
  input  wire logic               decimated_stall,
  output logic signed [13:0]      decimated_sample
);
  import ahbd_pkg::*;

  cmd_t    cmd;
  status_t status;

  ahbd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .audio_valid (audio_valid),
    .audio_stall (audio_stall),
    .status      (status),
    .cmd         (cmd)
  );

  ahbd_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .audio_sample     (audio_sample),
    .cmd              (cmd),
    .status           (status),
    .decimated_valid  (decimated_valid),
    .decimated_stall  (decimated_stall),
    .decimated_sample (decimated_sample)
  );

  // A result must never overwrite one that is still held.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(decimated_valid && decimated_stall))
    else $error("result loaded over a held beat");

  // Once a beat is taken the input stays stalled while the sample is in work.
  assert property (@(posedge clk) disable iff (rst)
    (audio_valid && !audio_stall) |=> audio_stall)
    else $error("input not stalled after a beat");

  // Results come only from the even branch, after which the phase is odd.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.phase)
    else $error("result produced on the odd phase");

endmodule

`default_nettype wire

### hdl/ahbd_ctrl.sv
// Sequencer for the decimator: steps one sample through the shared multiplier.
// Depends on ahbd_pkg for the command and status bundles.
`default_nettype none

module ahbd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             audio_valid,
  output logic                  audio_stall,
  input  wire ahbd_pkg::status_t status,
  output ahbd_pkg::cmd_t        cmd
);
  import ahbd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_ADD0 = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_ADD1 = 3'd4;
  localparam logic [2:0] S_MULO = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign audio_stall = (state != S_IDLE);

  // Next state and commands for the datapath.
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (audio_valid) begin
          cmd.load_x = 1'b1;
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_SEC0;
        state_next  = S_ADD0;
      end
      S_ADD0: begin
        cmd.upd_mid = 1'b1;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_SEC1;
        state_next  = S_ADD1;
      end
      S_ADD1: begin
        cmd.upd_out = 1'b1;
        // Only the even branch produces a result.
        state_next = status.phase ? S_IDLE : S_MULO;
      end
      S_MULO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_OUT;
        state_next  = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/ahbd_datapath.sv
// Datapath: branch taps, shared multiplier, output scaling and the output register.
// Depends on ahbd_pkg; driven by commands from ahbd_ctrl.
`default_nettype none

module ahbd_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic signed [15:0]  audio_sample,
  input  wire ahbd_pkg::cmd_t      cmd,
  output ahbd_pkg::status_t        status,
  output logic                     decimated_valid,
  input  wire logic                decimated_stall,
  output logic signed [13:0]       decimated_sample
);
  import ahbd_pkg::*;

  logic   phase;
  state_t even_taps [3];
  state_t odd_taps [3];
  state_t tap [3];
  state_t x_r;
  state_t mid_r;
  prod_t  p;
  logic   neg_r;
  logic [15:0] bq;

  logic signed [20:0] x21;
  wide_t  shp;
  state_t mid_new;
  state_t y_new;
  mop_t   mop;
  coef_t  mcoef;
  coef_t  k0;
  coef_t  k1;
  mop_t   s;
  logic [SW:0] a;
  logic [SW-7:0] b;
  logic [13:0] qm;
  logic [13:0] out_next;

  assign status.phase    = phase;
  assign status.out_busy = decimated_valid & decimated_stall;

  // Taps and coefficients of the branch that the current sample belongs to.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tap[i] = phase ? odd_taps[i] : even_taps[i];
    end
    k0 = phase ? K_ODD0 : K_EVEN0;
    k1 = phase ? K_ODD1 : K_EVEN1;
  end

  // Scaled input, 1.0 at 2^20.
  assign x21 = {audio_sample, 5'b0};

  // Floor of the product over 2^15 is the upper part of the product.
  assign shp     = wide_t'($signed(p[FRAC+SW+2:FRAC]));
  assign mid_new = sat_state(shp + wide_t'(tap[0]));
  assign y_new   = sat_state(shp + wide_t'(tap[1]));

  // Multiplier operand selection.
  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_SEC0: begin
        mop   = mop_t'(x_r) - mop_t'(tap[1]);
        mcoef = k0;
      end
      MSEL_SEC1: begin
        mop   = mop_t'(mid_r) - mop_t'(tap[2]);
        mcoef = k1;
      end
      MSEL_OUT: begin
        mop   = mop_t'($signed({1'b0, bq}));
        mcoef = RECIP5;
      end
      default: begin
        mop   = '0;
        mcoef = '0;
      end
    endcase
  end

  // Sum of both branches and its magnitude over 128.
  assign s = mop_t'(y_new) + mop_t'(odd_taps[2]);
  assign a = s[SW] ? (~s + mop_t'(1)) : s;
  assign b = a[SW:7];

  // Quotient magnitude, then sign and saturation.
  assign qm       = p[RECIP_SHIFT+13:RECIP_SHIFT];
  assign out_next = neg_r ? (~qm + 14'd1) : (qm[13] ? OUT_MAX : qm);

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_r <= sat_state(wide_t'(x21));
    end
    if (cmd.mul_en) begin
      p <= mop * mcoef;
    end
    if (cmd.upd_mid) begin
      mid_r <= mid_new;
    end
    if (cmd.upd_out) begin
      neg_r <= s[SW];
      bq    <= (b > B_LIMIT) ? B_LIMIT : 16'(b);
    end
    if (cmd.load_out) begin
      decimated_sample <= out_next;
    end
  end

  // Branch state and phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        even_taps[i] <= '0;
        odd_taps[i]  <= '0;
      end
    end else begin
      if (cmd.upd_mid) begin
        if (phase) begin
          odd_taps[0] <= x_r;
        end else begin
          even_taps[0] <= x_r;
        end
      end
      if (cmd.upd_out) begin
        phase <= ~phase;
        if (phase) begin
          odd_taps[1] <= mid_r;
          odd_taps[2] <= y_new;
        end else begin
          even_taps[1] <= mid_r;
          even_taps[2] <= y_new;
        end
      end
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      decimated_valid <= 1'b0;
    end else if (cmd.load_out) begin
      decimated_valid <= 1'b1;
    end else if (!decimated_stall) begin
      decimated_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
